// ----- rtl/dsh_pkg.sv -----
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and constants of the diamond-square heightmap unit.
// ----------------------------------------------------------------------------
package dsh_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int HEIGHT_W      = 24;
    localparam int POS_W         = 11;
    localparam int ROUGH_W       = 16;
    localparam int ORDER_W       = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_ORDER_DEF = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam int HEIGHT_MAX = 8388607;
    localparam int HEIGHT_MIN = -8388608;

    // sum of neighbours: four signed 24-bit heights
    localparam int SUM_W = HEIGHT_W + 2;

    // divide by three: q = (m * RECIP3) >> RECIP3_SHIFT, exact for m < 2^25
    localparam int               RECIP3_W     = 26;
    localparam int               RECIP3_SHIFT = 27;
    localparam logic [RECIP3_W-1:0] RECIP3    = 26'd44739243;

    // Q1.15 sample times amplitude, back to Q16.8
    localparam int OFFS_SHIFT = 15;

    localparam logic [ROUGH_W-1:0] ROUGH_RESET = 16'd256;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ORDER = 1'b1;

    typedef enum logic {
        CMD_DRAW,
        CMD_RESTART
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_READ2,
        ST_MUL,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] random_sample;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]           x_pos;
        logic [POS_W-1:0]           y_pos;
        logic signed [HEIGHT_W-1:0] height;
        logic                       last_point;
    } out_item_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

endpackage

// ----- rtl/dsh_front.sv -----
// ----------------------------------------------------------------------------
// dsh_front
// Input side: accepts items, tags them as draw or restart commands and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dsh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dsh_pkg::in_item_t in_data,
    output dsh_pkg::qhead_t   head,
    input  logic              pop
);
    import dsh_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t            queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    qentry_t            entry_in;

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    always_comb
    begin
        entry_in.cmd    = in_data.kind ? CMD_RESTART : CMD_DRAW;
        entry_in.sample = in_data.random_sample;
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");
`endif

endmodule

// ----- rtl/dsh_back.sv -----
// ----------------------------------------------------------------------------
// dsh_back
// Execution side: walks the grid, reads neighbour heights from the store,
// forms mean plus scaled random offset, saturates, writes back and presents
// the point. Also holds the configuration registers and the clearing sweep.
// ----------------------------------------------------------------------------
module dsh_back #(
    parameter int MAX_ORDER = dsh_pkg::MAX_ORDER_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [dsh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dsh_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  dsh_pkg::qhead_t                     head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dsh_pkg::out_item_t                  out_data
);
    import dsh_pkg::*;

    localparam int CW      = MAX_ORDER + 1;           // coordinate width, holds 2^MAX_ORDER
    localparam int NW      = CW + 1;                  // coordinate arithmetic width
    localparam int SIDE    = (1 << MAX_ORDER) + 1;
    localparam int DEPTH   = SIDE * SIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int DIV_W   = SUM_W + RECIP3_W;
    localparam int Q_W     = DIV_W - RECIP3_SHIFT;
    localparam int PROD_W  = SAMPLE_W + ROUGH_W + 1;
    localparam int HV_W    = SUM_W + 1;

    localparam logic signed [HV_W-1:0] HV_HI = HV_W'(HEIGHT_MAX);
    localparam logic signed [HV_W-1:0] HV_LO = HV_W'(HEIGHT_MIN);

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] k);
        logic [ORDER_W-1:0] r;
        r = k;
        if (k == '0)
        begin
            r = ORDER_W'(1);
        end
        else if (k > ORDER_W'(MAX_ORDER))
        begin
            r = ORDER_W'(MAX_ORDER);
        end
        return r;
    endfunction

    // row-major address with the largest side as pitch: y * SIDE + x
    function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] x, input logic [NW-1:0] y);
        return (AW'(y[CW-1:0]) << MAX_ORDER) + AW'(y[CW-1:0]) + AW'(x[CW-1:0]);
    endfunction

    // ---------------------------------------------------------------- state
    back_state_t                 state_reg, state_next;
    logic [AW-1:0]               clr_addr_reg, clr_addr_next;
    logic [ROUGH_W-1:0]          roughness_reg, roughness_next;
    logic [ORDER_W-1:0]          grid_order_reg, grid_order_next;
    logic [ORDER_W-1:0]          active_order_reg, active_order_next;
    logic [ORDER_W-1:0]          level_reg, level_next;
    logic                        diamond_reg, diamond_next;
    logic [CW-1:0]               row_reg, row_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [CW-1:0]               half_reg, half_next;
    logic                        finished_reg, finished_next;
    logic                        out_valid_reg, out_valid_next;
    out_item_t                   out_reg, out_next;

    logic signed [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [3:0]                  mask_reg, mask_next;
    logic signed [SUM_W-1:0]     acc_reg, acc_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [DIV_W-1:0]            div3_reg, div3_next;
    logic signed [HEIGHT_W-1:0]  rd0_data_reg, rd1_data_reg;

    // ---------------------------------------------------------------- memory
    logic signed [HEIGHT_W-1:0]  store_mem [DEPTH];
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic signed [HEIGHT_W-1:0]  mem_wdata;
    logic [AW-1:0]               rd0_addr, rd1_addr;

    // ---------------------------------------------------------------- comb
    logic [NW-1:0]               xw, yw, hw, top_w;
    logic [NW-1:0]               xm, xp, ym, yp;
    logic [AW-1:0]               n_addr [4];
    logic [3:0]                  nbr_mask;
    logic [2:0]                  nbr_cnt;
    logic                        slot_free;
    logic                        do_restart;
    logic [ORDER_W-1:0]          restart_order;
    logic [ROUGH_W-1:0]          amp;
    logic [SUM_W-1:0]            acc_mag;
    logic                        acc_neg;
    logic [Q_W-1:0]              quot3;
    logic signed [SUM_W-1:0]     mean;
    logic signed [PROD_W-1:0]    offs;
    logic signed [HV_W-1:0]      hv;
    logic signed [HEIGHT_W-1:0]  hv_sat;
    logic signed [SUM_W-1:0]     pair_lo, pair_hi;
    logic [NW-1:0]               col_step, row_step2, row_step1;

    assign xw    = {1'b0, col_reg};
    assign yw    = {1'b0, row_reg};
    assign hw    = {1'b0, half_reg};
    assign top_w = NW'(1) << active_order_reg;
    assign xm    = xw - hw;
    assign xp    = xw + hw;
    assign ym    = yw - hw;
    assign yp    = yw + hw;

    always_comb
    begin
        if (!diamond_reg)
        begin
            n_addr[0] = addr_of(xm, ym);
            n_addr[1] = addr_of(xp, ym);
            n_addr[2] = addr_of(xm, yp);
            n_addr[3] = addr_of(xp, yp);
            nbr_mask  = (xw >= hw && yw >= hw && xp <= top_w && yp <= top_w) ? 4'hF : 4'h0;
        end
        else
        begin
            n_addr[0] = addr_of(xw, yp);
            n_addr[1] = addr_of(xw, ym);
            n_addr[2] = addr_of(xm, yw);
            n_addr[3] = addr_of(xp, yw);
            nbr_mask  = {xp <= top_w, xw >= hw, yw >= hw, yp <= top_w};
        end
    end

    assign rd0_addr = (state_reg == ST_READ1) ? n_addr[2] : n_addr[0];
    assign rd1_addr = (state_reg == ST_READ1) ? n_addr[3] : n_addr[1];

    assign nbr_cnt   = 3'($countones(mask_reg));
    assign slot_free = !out_valid_reg || out_ready;
    assign amp       = roughness_reg >> level_reg;
    assign acc_neg   = acc_reg[SUM_W-1];
    assign acc_mag   = acc_neg ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign quot3     = div3_reg[DIV_W-1:RECIP3_SHIFT];

    // pair data selected by the mask of the pair whose read data is now registered
    always_comb
    begin
        if (state_reg == ST_READ2)
        begin
            pair_lo = mask_reg[2] ? SUM_W'(rd0_data_reg) : '0;
            pair_hi = mask_reg[3] ? SUM_W'(rd1_data_reg) : '0;
        end
        else
        begin
            pair_lo = mask_reg[0] ? SUM_W'(rd0_data_reg) : '0;
            pair_hi = mask_reg[1] ? SUM_W'(rd1_data_reg) : '0;
        end
    end

    // mean truncated toward zero
    always_comb
    begin
        case (nbr_cnt)
            3'd4:    mean = $signed(acc_reg + (acc_neg ? SUM_W'(3) : SUM_W'(0))) >>> 2;
            3'd3:    mean = acc_neg ? -$signed(SUM_W'(quot3)) : $signed(SUM_W'(quot3));
            3'd2:    mean = $signed(acc_reg + (acc_neg ? SUM_W'(1) : SUM_W'(0))) >>> 1;
            3'd1:    mean = acc_reg;
            default: mean = '0;
        endcase
    end

    assign offs = prod_reg >>> OFFS_SHIFT;
    assign hv   = HV_W'(mean) + HV_W'(offs);

    always_comb
    begin
        if (hv > HV_HI)
        begin
            hv_sat = HEIGHT_W'(HV_HI);
        end
        else if (hv < HV_LO)
        begin
            hv_sat = HEIGHT_W'(HV_LO);
        end
        else
        begin
            hv_sat = HEIGHT_W'(hv);
        end
    end

    assign col_step  = xw + (hw << 1);
    assign row_step2 = yw + (hw << 1);
    assign row_step1 = yw + hw;

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        roughness_next    = roughness_reg;
        grid_order_next   = grid_order_reg;
        active_order_next = active_order_reg;
        level_next        = level_reg;
        diamond_next      = diamond_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        half_next         = half_reg;
        finished_next     = finished_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        sample_next       = sample_reg;
        mask_next         = mask_reg;
        acc_next          = acc_reg;
        prod_next         = prod_reg;
        div3_next         = div3_reg;
        mem_we            = 1'b0;
        mem_waddr         = clr_addr_reg;
        mem_wdata         = '0;
        pop               = 1'b0;
        do_restart        = 1'b0;
        restart_order     = grid_order_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.entry.cmd == CMD_RESTART)
                    begin
                        do_restart = 1'b1;
                    end
                    else if (!finished_reg)
                    begin
                        sample_next = head.entry.sample;
                        mask_next   = nbr_mask;
                        acc_next    = '0;
                        state_next  = ST_READ0;
                    end
                end
            end
            ST_READ0:
            begin
                state_next = ST_READ1;
            end
            ST_READ1:
            begin
                acc_next   = acc_reg + pair_lo + pair_hi;
                state_next = ST_READ2;
            end
            ST_READ2:
            begin
                acc_next   = acc_reg + pair_lo + pair_hi;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(sample_reg) * PROD_W'($signed({1'b0, amp}));
                div3_next  = DIV_W'(acc_mag) * DIV_W'(RECIP3);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(xw, yw);
                    mem_wdata = hv_sat;

                    // walk to the next point
                    if (col_step <= top_w)
                    begin
                        col_next = CW'(col_step);
                    end
                    else if (!diamond_reg)
                    begin
                        col_next = half_reg;
                        if (row_step2 > top_w)
                        begin
                            diamond_next = 1'b1;
                            row_next     = '0;
                        end
                        else
                        begin
                            row_next = CW'(row_step2);
                        end
                    end
                    else if (row_step1 <= top_w)
                    begin
                        row_next = CW'(row_step1);
                        // odd multiple of h starts at column zero
                        col_next = ((row_step1 & hw) != '0) ? '0 : half_reg;
                    end
                    else if (level_reg >= active_order_reg)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        level_next   = level_reg + 1'b1;
                        half_next    = half_reg >> 1;
                        diamond_next = 1'b0;
                        row_next     = half_reg >> 1;
                        col_next     = half_reg >> 1;
                    end

                    out_next.x_pos      = POS_W'(col_reg);
                    out_next.y_pos      = POS_W'(row_reg);
                    out_next.height     = hv_sat;
                    out_next.last_point = finished_next;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_index == REG_ROUGHNESS)
            begin
                roughness_next = cfg_data[ROUGH_W-1:0];
            end
            else if (cfg_index == REG_GRID_ORDER)
            begin
                grid_order_next = cfg_data[ORDER_W-1:0];
                restart_order   = cfg_data[ORDER_W-1:0];
                do_restart      = 1'b1;
            end
        end

        if (do_restart)
        begin
            active_order_next = clamp_order(restart_order);
            level_next        = ORDER_W'(1);
            diamond_next      = 1'b0;
            half_next         = CW'(1) << (clamp_order(restart_order) - 1'b1);
            row_next          = CW'(1) << (clamp_order(restart_order) - 1'b1);
            col_next          = CW'(1) << (clamp_order(restart_order) - 1'b1);
            finished_next     = 1'b0;
            clr_addr_next     = '0;
            state_next        = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            roughness_reg    <= ROUGH_RESET;
            grid_order_reg   <= ORDER_RESET;
            active_order_reg <= clamp_order(ORDER_RESET);
            level_reg        <= ORDER_W'(1);
            diamond_reg      <= 1'b0;
            half_reg         <= CW'(1) << (clamp_order(ORDER_RESET) - 1'b1);
            row_reg          <= CW'(1) << (clamp_order(ORDER_RESET) - 1'b1);
            col_reg          <= CW'(1) << (clamp_order(ORDER_RESET) - 1'b1);
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            roughness_reg    <= roughness_next;
            grid_order_reg   <= grid_order_next;
            active_order_reg <= active_order_next;
            level_reg        <= level_next;
            diamond_reg      <= diamond_next;
            half_reg         <= half_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            finished_reg     <= finished_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        sample_reg <= sample_next;
        mask_reg   <= mask_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        div3_reg   <= div3_next;
    end

    // height store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd0_data_reg <= store_mem[rd0_addr];
        rd1_data_reg <= store_mem[rd1_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !pop)
        else $error("command taken during clearing sweep");

    a_nbr_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ0 |-> (nbr_cnt == 3'd3 || nbr_cnt == 3'd4))
        else $error("point has neither three nor four neighbours");

    a_no_draw_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ0 |-> !finished_reg)
        else $error("draw started after map completed");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && slot_free && !cfg_write) |=> out_valid_reg)
        else $error("finished point not presented");
`endif

endmodule

// ----- rtl/diamond_square_heightmap_unit.sv -----
// ----------------------------------------------------------------------------
// diamond_square_heightmap_unit
// Diamond-square heightmap generator: one random draw in, one grid point out.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   in       | input     | in_valid/in_ready   | kind, random_sample
//   out      | output    | out_valid/out_ready | x_pos, y_pos, height, last_pt
//   cfg      | input     | cfg_write           | cfg_index, cfg_data
//
// A draw in the back end goes through queue pop, reads of two neighbour pairs
// on the store's two read ports, read data, multiply, saturate and write back.
// A draw after the map is complete is popped and dropped.
// Reset, a restart item and a grid_order write start a clearing sweep over
// all (2^MAX_ORDER+1)^2 store entries (1089 at the default); no command runs
// during it. The input queue keeps accepting items while it has room, also
// while the back end works or the output register waits for out_ready.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_unit #(
    parameter int MAX_ORDER = dsh_pkg::MAX_ORDER_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [dsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dsh_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dsh_pkg::out_item_t             out_data
);
    import dsh_pkg::*;

    qhead_t head;
    logic   pop;

    dsh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    dsh_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
